### hdl/bac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bac_pkg: shared types and constants for the block affine cipher
// Register map codes, controller command and status structs.
// ----------------------------------------------------------------------------
package bac_pkg;

  localparam int MAX_BLOCK  = 8;
  localparam int VALUE_BITS = 64;

  localparam logic [2:0] REG_MODULUS  = 3'd0;
  localparam logic [2:0] REG_BLKLEN   = 3'd1;
  localparam logic [2:0] REG_DECRYPT  = 3'd2;
  localparam logic [2:0] REG_MULT     = 3'd3;
  localparam logic [2:0] REG_ADD      = 3'd4;
  localparam logic [2:0] REG_INVERSE  = 3'd5;

  localparam logic [7:0] PAD_DIGIT = 8'd0;

  // controller -> datapath
  typedef struct packed {
    logic absorb;     // accumulate input symbol
    logic pad;        // accumulate one pad digit
    logic space_init; // start block space computation
    logic space_step; // one factor of m
    logic prep;       // load x, b, key
    logic sub_b;      // decrypt: x - b
    logic mul_init;   // start modular multiply
    logic mul_step;   // one bit of multiply
    logic add_b;      // encrypt: y + b
    logic div_init;   // start digit extraction
    logic div_step;   // one quotient bit
    logic div_done;   // store digit, clear remainder
    logic clear;      // clear block state
  } bac_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       full;      // block complete
    logic       space_last;
    logic       mul_last;
    logic       div_last;
  } bac_sts_t;

endpackage

### hdl/bac_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bac_datapath: block accumulator and modular arithmetic
// Shift-add modular multiply, restoring division by m, digit buffer.
// ----------------------------------------------------------------------------
module bac_datapath #(
  parameter int MAX_BLOCK  = bac_pkg::MAX_BLOCK,
  parameter int VALUE_BITS = bac_pkg::VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bac_pkg::bac_cmd_t     cmd,
  output bac_pkg::bac_sts_t     sts,
  input  logic [8:0]            modulus,
  input  logic [3:0]            block_length,
  input  logic                  decrypt_mode,
  input  logic [63:0]           mult_key,
  input  logic [63:0]           add_key,
  input  logic [63:0]           inverse_key,
  input  logic [7:0]            symbol_in,
  input  logic [$clog2(MAX_BLOCK+1)-1:0] out_idx,
  output logic [7:0]            digit,
  output logic [$clog2(MAX_BLOCK+1)-1:0] eff_n
);

  localparam int VB = VALUE_BITS;
  localparam int CW = $clog2(MAX_BLOCK + 1);
  localparam int BW = $clog2(VB);
  localparam int IW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam logic [7:0] PAD_PAD = bac_pkg::PAD_DIGIT;

  logic [8:0]    m;
  logic [VB-1:0] mask_v;
  logic [VB-1:0] block_value;
  logic [CW-1:0] collected;
  logic [3:0]    coll_raw;
  logic [VB-1:0] space;
  logic          space_full;
  logic [CW-1:0] scnt;
  logic [VB-1:0] x, b, key, r;
  logic [BW-1:0] bit_idx;
  logic [VB-1:0] quo;
  logic [8:0]    rem;
  logic [CW-1:0] dcnt;
  logic [7:0]    digit_buffer [MAX_BLOCK];

  assign mask_v = {VB{1'b1}};
  assign m = (modulus < 9'd2) ? 9'd2 : ((modulus > 9'd256) ? 9'd256 : modulus);
  always_comb begin
    if (block_length == 4'd0) eff_n = CW'(1);
    else if (block_length > 4'(MAX_BLOCK)) eff_n = CW'(MAX_BLOCK);
    else eff_n = block_length[CW-1:0] & {CW{1'b1}};
  end
  assign collected = coll_raw[CW-1:0];

  function automatic logic [VB-1:0] addm(input logic [VB-1:0] u, input logic [VB-1:0] v,
                                         input logic [VB-1:0] sp, input logic full);
    logic [VB:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (!full && (s[VB] || s[VB-1:0] >= sp)) s = s - {1'b0, sp};
    return s[VB-1:0];
  endfunction

  // space product p*m, overflow detect
  logic [VB+8:0] sprod;
  assign sprod = space * m;

  // block accumulate product (modulo 2^VB), with symbol
  logic [VB+8:0] bprod;
  assign bprod = block_value * m;

  // restoring division: bring in one bit of quotient register
  logic [9:0] trial;
  assign trial = {rem, quo[VB-1]} - {1'b0, m};

  always_ff @(posedge clk) begin
    if (rst) begin
      block_value <= '0;
      coll_raw    <= '0;
    end else if (cmd.clear) begin
      block_value <= '0;
      coll_raw    <= '0;
    end else if (cmd.absorb) begin
      block_value <= bprod[VB-1:0] + VB'(symbol_in);
      coll_raw    <= coll_raw + 4'd1;
    end else if (cmd.pad) begin
      block_value <= bprod[VB-1:0] + VB'(PAD_PAD);
      coll_raw    <= coll_raw + 4'd1;
    end
  end

  assign sts.full = (coll_raw >= 4'(eff_n));

  always_ff @(posedge clk) begin
    if (cmd.space_init) begin
      space <= VB'(1);
      space_full <= 1'b0;
      scnt <= '0;
    end else if (cmd.space_step && !space_full) begin
      if (sprod[VB+8:VB] != '0) space_full <= 1'b1;
      else space <= sprod[VB-1:0];
      scnt <= scnt + CW'(1);
    end else if (cmd.space_step) begin
      scnt <= scnt + CW'(1);
    end
  end
  assign sts.space_last = (scnt + CW'(1) >= eff_n);

  // multiplier operand sequencing: pass 0 reduces x (1*x), pass 1 reduces b,
  // pass 2 reduces key, pass 3 computes key*x. Controlled by pass.
  logic [1:0]    pass;
  logic [VB-1:0] ma, mx;
  always_comb begin
    case (pass)
      2'd0: begin ma = VB'(1); mx = x; end
      2'd1: begin ma = VB'(1); mx = b; end
      2'd2: begin ma = VB'(1); mx = key; end
      default: begin ma = key; mx = x; end
    endcase
  end

  // operand x for passes 0..2 may be >= space; addm assumes u,v < space,
  // so reduce it first by the shift-add with bits of the operand itself.
  logic [VB-1:0] rr;
  always_comb begin
    rr = addm(r, r, space, space_full);
    if (pass != 2'd3) begin
      if (mx[bit_idx]) rr = addm(rr, VB'(1), space, space_full);
    end else if (ma[bit_idx]) begin
      rr = addm(rr, mx, space, space_full);
    end
  end

  // -b in the block space, used once b and x are reduced
  logic [VB-1:0] negb;
  assign negb = space_full ? ((~b + VB'(1)) & mask_v) : (space - b);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      x   <= block_value;
      b   <= add_key[VB-1:0];
      key <= decrypt_mode ? inverse_key[VB-1:0] : mult_key[VB-1:0];
    end else if (cmd.mul_step && bit_idx == '0) begin
      case (pass)
        2'd0: x <= rr;
        2'd1: b <= rr;
        2'd2: begin
          key <= rr;
          // decrypt: x - b ahead of the key multiply
          if (cmd.sub_b) x <= addm(x, negb, space, space_full);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pass <= 2'd0;
    else if (cmd.space_init) pass <= 2'd0;
    else if (cmd.mul_step && bit_idx == '0) pass <= pass + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_init) begin
      r <= '0;
      bit_idx <= BW'(VB - 1);
    end else if (cmd.mul_step) begin
      // each reduction pass starts from zero; the product pass keeps its result
      r <= (bit_idx == '0 && pass != 2'd3) ? '0 : rr;
      bit_idx <= bit_idx - BW'(1);
    end else if (cmd.add_b) begin
      r <= addm(r, b, space, space_full);
    end
  end
  assign sts.mul_last = (bit_idx == '0) && (pass == 2'd3);

  logic [BW-1:0] qcnt;
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo  <= r;
      rem  <= '0;
      qcnt <= BW'(VB - 1);
      dcnt <= eff_n;
    end else if (cmd.div_step) begin
      if (!trial[9]) rem <= trial[8:0];
      else rem <= {rem[7:0], quo[VB-1]};
      quo  <= {quo[VB-2:0], ~trial[9]};
      qcnt <= qcnt - BW'(1);
    end else if (cmd.div_done) begin
      digit_buffer[IW'(dcnt - CW'(1))] <= rem[7:0];
      rem  <= '0;
      qcnt <= BW'(VB - 1);
      dcnt <= dcnt - CW'(1);
    end
  end
  assign sts.div_last = (qcnt == '0);
  assign digit = digit_buffer[IW'(out_idx)];

endmodule

### hdl/bac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bac_ctrl: sequencer for the block affine cipher
// Collects symbols, runs the arithmetic passes and streams the digits.
// ----------------------------------------------------------------------------
module bac_ctrl #(
  parameter int MAX_BLOCK = bac_pkg::MAX_BLOCK
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              in_last,
  input  logic              decrypt_mode,
  input  bac_pkg::bac_sts_t sts,
  input  logic [$clog2(MAX_BLOCK+1)-1:0] eff_n,
  output bac_pkg::bac_cmd_t cmd,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [$clog2(MAX_BLOCK+1)-1:0] out_idx,
  output logic              out_lblk,
  output logic              out_lmsg
);

  localparam int CW = $clog2(MAX_BLOCK + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_PAD   = 11'b00000000010,
    S_SPACE = 11'b00000000100,
    S_PREP  = 11'b00000001000,
    S_MUL   = 11'b00000010000,
    S_FIX   = 11'b00000100000,
    S_DIV   = 11'b00001000000,
    S_DIGIT = 11'b00010000000,
    S_OUT   = 11'b00100000000,
    S_CHECK = 11'b01000000000,
    S_STORE = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   eom;
  logic [CW-1:0] dleft;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_lblk  = (out_idx + CW'(1) == eff_n);
  assign out_lmsg  = out_lblk && eom;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_fire) begin
        cmd.absorb = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.full) begin
          cmd.space_init = 1'b1;
          state_next = S_SPACE;
        end else if (eom) state_next = S_PAD;
        else state_next = S_IDLE;
      end
      S_PAD: begin
        if (sts.full) begin
          cmd.space_init = 1'b1;
          state_next = S_SPACE;
        end else cmd.pad = 1'b1;
      end
      S_SPACE: begin
        cmd.space_step = 1'b1;
        if (sts.space_last) state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        cmd.clear = 1'b1;
        cmd.mul_init = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.sub_b = decrypt_mode;
        if (sts.mul_last) state_next = S_FIX;
      end
      S_FIX: begin
        state_next = S_DIV;
        cmd.div_init = 1'b1;
        if (!decrypt_mode) begin
          cmd.add_b = 1'b1;
          cmd.div_init = 1'b0;
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_STORE;
      end
      S_STORE: begin
        cmd.div_done = 1'b1;
        if (dleft == CW'(1)) state_next = S_OUT;
        else state_next = S_DIV;
      end
      S_OUT: if (out_ready && out_lblk) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // digit count and output index run beside the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      eom <= 1'b0;
      out_idx <= '0;
      dleft <= '0;
    end else begin
      state <= state_next;
      if (in_fire) eom <= in_last;
      if (cmd.div_init) dleft <= eff_n;
      else if (cmd.div_done) dleft <= dleft - CW'(1);
      if (state == S_OUT && out_ready) begin
        if (out_lblk) out_idx <= '0;
        else out_idx <= out_idx + CW'(1);
      end
    end
  end

endmodule

### hdl/block_affine_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_affine_cipher_top: polygraphic affine cipher over a base-m alphabet
//
//  port group   dir  beat contents
//  s_axis_*     in   tdata[7:0] symbol_in; tlast end_of_message
//  m_axis_*     out  tdata[7:0] symbol_out; tlast last_of_block;
//                    tuser last_of_message
//  APB          in   6 registers at 8*i
//
// A symbol that does not close a block passes through the check state
// before the next is accepted. A closing symbol runs the pad digits, n
// space steps, four shift-add passes and n divisions by m, then n output
// beats.
// Reset is synchronous; output stalls hold the beat and the input.
// ----------------------------------------------------------------------------
module block_affine_cipher_top #(
  parameter int MAX_BLOCK  = bac_pkg::MAX_BLOCK,
  parameter int VALUE_BITS = bac_pkg::VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] symbol_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] symbol_out
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,  // [0] last_of_message
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_BLOCK + 1);

  logic [8:0]  modulus;
  logic [3:0]  block_length;
  logic        decrypt_mode;
  logic [63:0] mult_key, add_key, inverse_key;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= 9'd26;
      block_length <= 4'd1;
      decrypt_mode <= 1'b0;
      mult_key <= 64'd1;
      add_key <= 64'd0;
      inverse_key <= 64'd1;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        bac_pkg::REG_MODULUS: modulus <= pwdata[8:0];
        bac_pkg::REG_BLKLEN:  block_length <= pwdata[3:0];
        bac_pkg::REG_DECRYPT: decrypt_mode <= pwdata[0];
        bac_pkg::REG_MULT:    mult_key <= pwdata;
        bac_pkg::REG_ADD:     add_key <= pwdata;
        bac_pkg::REG_INVERSE: inverse_key <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      bac_pkg::REG_MODULUS: prdata = 64'(modulus);
      bac_pkg::REG_BLKLEN:  prdata = 64'(block_length);
      bac_pkg::REG_DECRYPT: prdata = 64'(decrypt_mode);
      bac_pkg::REG_MULT:    prdata = mult_key;
      bac_pkg::REG_ADD:     prdata = add_key;
      bac_pkg::REG_INVERSE: prdata = inverse_key;
      default:              prdata = '0;
    endcase
  end

  bac_pkg::bac_cmd_t cmd;
  bac_pkg::bac_sts_t sts;
  logic [CW-1:0] out_idx, eff_n;

  bac_ctrl #(.MAX_BLOCK(MAX_BLOCK)) u_ctrl (
    .clk, .rst,
    .in_fire(s_axis_tvalid && s_axis_tready),
    .in_last(s_axis_tlast),
    .decrypt_mode,
    .sts, .eff_n, .cmd,
    .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_idx,
    .out_lblk(m_axis_tlast),
    .out_lmsg(m_axis_tuser)
  );

  bac_datapath #(.MAX_BLOCK(MAX_BLOCK), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst, .cmd, .sts,
    .modulus, .block_length, .decrypt_mode,
    .mult_key, .add_key, .inverse_key,
    .symbol_in(s_axis_tdata),
    .out_idx,
    .digit(m_axis_tdata),
    .eff_n
  );

endmodule
